/* rtl/frm_pkg.sv */
// shared types and constants of the frame rate monitor
package frm_pkg;

    // field widths
    localparam int FT_W       = 16;
    localparam int TGT_W      = 8;
    localparam int WIN_W      = 16;
    localparam int LWP_W      = 7;
    localparam int RATE_OUT_W = 18;
    localparam int LOAD_OUT_W = 15;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int ELAP_W     = 17;
    localparam int WFR_W      = 32;
    localparam int K1000_W    = 10;
    localparam int TGT100_W   = 15;

    // arithmetic constants
    localparam int K1000       = 1000;
    localparam int LOAD_FULL   = 100;
    localparam int EMA_NEW_WT  = 3;
    localparam int EMA_OLD_WT  = 7;
    localparam int EMA_DIV     = 10;
    localparam int MIN_SAMPLES = 4;

    // parameter defaults
    localparam int RING_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // register reset values
    localparam logic [TGT_W-1:0] TARGET_FPS_RST = 8'd60;
    localparam logic [WIN_W-1:0] WINDOW_MS_RST  = 16'd1000;
    localparam logic [LWP_W-1:0] LOAD_WARN_RST  = 7'd80;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_WARN  = 2'd2;

    // quality level codes
    localparam logic [LEVEL_W-1:0] QL_LOW    = 2'd0;
    localparam logic [LEVEL_W-1:0] QL_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] QL_HIGH   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SETUP,
        S_DIVIDE,
        S_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        OP_WIN,
        OP_EMA,
        OP_CUR,
        OP_AVG,
        OP_LOAD
    } op_t;

endpackage

/* rtl/frame_rate_monitor_top.sv */
// frame rate monitor: frame time ring, windowed ema, rate, load and quality outputs
// per input: ring update, then the divisions for current rate, average rate and load
// a closing window first adds a window rate division and, past the first ema load, an ema one
// one shared one-bit-a-cycle divider; no input is taken before the last result is registered
// the next input transfer is taken while a finished result still waits on m_ready
// reset: synchronous, aresetn low; registers go to 60/1000/80, ring, window and ema clear
module frame_rate_monitor_top
    import frm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FT_W-1:0]       s_frame_time_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RATE_OUT_W-1:0] m_current_fps_q8,
    output logic [RATE_OUT_W-1:0] m_average_fps_q8,
    output logic [LOAD_OUT_W-1:0] m_load_pct_q8,
    output logic                  m_reduce_quality,
    output logic [LEVEL_W-1:0]    m_quality_level,
    output logic [RATE_OUT_W-1:0] m_ema_fps_q8
);

    localparam int          PTR_W    = $clog2(RING_DEPTH);
    localparam int          CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int          SUM_W    = FT_W + PTR_W;
    localparam int unsigned RATE_MAX = K1000 << FRAC_BITS;
    localparam int unsigned LOAD_CAP = LOAD_FULL << FRAC_BITS;
    localparam int          QW       = $clog2(RATE_MAX + 1);
    localparam int          NUM_W    = WFR_W + K1000_W + FRAC_BITS;
    localparam int          DEN_W    = SUM_W;
    localparam int          THR_W    = QW + 4;
    localparam int          C1K_W    = CNT_W + K1000_W;
    localparam int          WPR_W    = WFR_W + K1000_W;
    localparam int          LPR_W    = SUM_W + TGT100_W;

    state_t state_reg, state_next;
    op_t    op_reg;

    // configuration
    logic [TGT_W-1:0]    target_fps_reg;
    logic [WIN_W-1:0]    window_ms_reg;
    logic [LWP_W-1:0]    load_warn_reg;

    // ring and window state
    logic [FT_W-1:0]     ring_mem [RING_DEPTH];
    logic [FT_W-1:0]     t_reg;
    logic [FT_W-1:0]     rd_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [ELAP_W-1:0]   elapsed_reg;
    logic [WFR_W-1:0]    frames_reg;
    logic [QW-1:0]       ema_reg;
    logic [QW-1:0]       w_reg;
    logic [TGT100_W-1:0] tgt100_reg;
    logic [QW-1:0]       cur_reg;
    logic [QW-1:0]       avg_reg;
    logic [QW-1:0]       load_reg;

    // result register
    logic                  m_valid_reg;
    logic [RATE_OUT_W-1:0] m_cur_reg;
    logic [RATE_OUT_W-1:0] m_avg_reg;
    logic [LOAD_OUT_W-1:0] m_load_reg;
    logic                  m_reduce_reg;
    logic [LEVEL_W-1:0]    m_level_reg;
    logic [RATE_OUT_W-1:0] m_ema_reg;

    logic              s_accept;
    logic              out_free;
    logic              window_close;
    logic              ring_full;
    logic [FT_W-1:0]   old_frame;
    logic [SUM_W-1:0]  sum_upd;
    logic              skip_op;
    logic              div_start;
    logic              div_done;
    logic [QW-1:0]     div_quot;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [QW-1:0]     div_cap;
    logic [C1K_W-1:0]  cnt1000;
    logic [WPR_W-1:0]  win_prod;
    logic [LPR_W-1:0]  load_prod;
    logic [QW+3:0]     ema_sum;
    logic [THR_W-1:0]  avg10;
    logic [THR_W-1:0]  tgt_q;
    logic [THR_W-1:0]  thr6;
    logic [THR_W-1:0]  thr8;
    logic [THR_W-1:0]  thr9;
    logic [QW-1:0]     warn_q;
    logic              reduce;
    logic [LEVEL_W-1:0] level;

    assign s_accept     = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign window_close = (elapsed_reg >= ELAP_W'(window_ms_reg));
    assign ring_full    = (count_reg == CNT_W'(RING_DEPTH));
    assign old_frame    = ring_full ? rd_reg : '0;
    assign sum_upd      = sum_reg - SUM_W'(old_frame) + SUM_W'(t_reg);
    assign skip_op      = ((op_reg == OP_WIN) && !window_close) ||
                          ((op_reg == OP_EMA) && (ema_reg == '0));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_fps_reg <= TARGET_FPS_RST;
            window_ms_reg  <= WINDOW_MS_RST;
            load_warn_reg  <= LOAD_WARN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_FPS: target_fps_reg <= cfg_wdata[TGT_W-1:0];
                REG_WINDOW_MS:  window_ms_reg  <= cfg_wdata[WIN_W-1:0];
                REG_LOAD_WARN:  load_warn_reg  <= cfg_wdata[LWP_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_accept) state_next = S_UPDATE;
            S_UPDATE: state_next = S_SETUP;
            S_SETUP:  if (!skip_op) state_next = S_DIVIDE;
            S_DIVIDE: begin
                if (div_done) begin
                    state_next = (op_reg == OP_LOAD) ? S_OUTPUT : S_SETUP;
                end
            end
            S_OUTPUT: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        div_start = (state_reg == S_SETUP) && !skip_op;
    end

    // ring memory, registered read of the entry about to be replaced
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg <= ring_mem[wp_reg];
            t_reg  <= s_frame_time_ms;
        end
        if (state_reg == S_UPDATE) begin
            ring_mem[wp_reg] <= t_reg;
        end
    end

    // ring pointer, fill count, sums, window and ema
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= OP_WIN;
            wp_reg      <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            elapsed_reg <= '0;
            frames_reg  <= '0;
            ema_reg     <= '0;
        end else begin
            unique case (state_reg)
                S_UPDATE: begin
                    op_reg      <= OP_WIN;
                    sum_reg     <= sum_upd;
                    wp_reg      <= (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                    elapsed_reg <= elapsed_reg + ELAP_W'(t_reg);
                    if (!ring_full) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (frames_reg != '1) begin
                        frames_reg <= frames_reg + WFR_W'(1);
                    end
                end
                S_SETUP: begin
                    if ((op_reg == OP_WIN) && !window_close) begin
                        op_reg <= OP_CUR;
                    end else if ((op_reg == OP_EMA) && (ema_reg == '0)) begin
                        ema_reg     <= w_reg;
                        elapsed_reg <= '0;
                        frames_reg  <= '0;
                        op_reg      <= OP_CUR;
                    end
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        unique case (op_reg)
                            OP_WIN:  op_reg <= OP_EMA;
                            OP_EMA: begin
                                ema_reg     <= div_quot;
                                elapsed_reg <= '0;
                                frames_reg  <= '0;
                                op_reg      <= OP_CUR;
                            end
                            OP_CUR:  op_reg <= OP_AVG;
                            OP_AVG:  op_reg <= OP_LOAD;
                            OP_LOAD: op_reg <= OP_WIN;
                            default: op_reg <= OP_WIN;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // quotient capture and target scaling
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPDATE) begin
            tgt100_reg <= TGT100_W'(target_fps_reg) * TGT100_W'(LOAD_FULL);
        end
        if ((state_reg == S_DIVIDE) && div_done) begin
            unique case (op_reg)
                OP_WIN:  w_reg    <= div_quot;
                OP_CUR:  cur_reg  <= div_quot;
                OP_AVG:  avg_reg  <= div_quot;
                OP_LOAD: load_reg <= div_quot;
                default: ;
            endcase
        end
    end

    // divider operands
    assign cnt1000   = C1K_W'(count_reg) * C1K_W'(K1000);
    assign win_prod  = WPR_W'(frames_reg) * WPR_W'(K1000);
    assign load_prod = LPR_W'(sum_reg) * LPR_W'(tgt100_reg);
    assign ema_sum   = (QW+4)'(w_reg) * (QW+4)'(EMA_NEW_WT) +
                       (QW+4)'(ema_reg) * (QW+4)'(EMA_OLD_WT);

    always_comb begin
        div_num = '0;
        div_den = '0;
        div_cap = QW'(RATE_MAX);
        unique case (op_reg)
            OP_WIN: begin
                div_num = NUM_W'({win_prod, {FRAC_BITS{1'b0}}});
                div_den = DEN_W'(elapsed_reg);
            end
            OP_EMA: begin
                div_num = NUM_W'(ema_sum);
                div_den = DEN_W'(EMA_DIV);
            end
            OP_CUR: begin
                div_num = NUM_W'(RATE_MAX);
                div_den = DEN_W'(t_reg);
            end
            OP_AVG: begin
                div_num = NUM_W'({cnt1000, {FRAC_BITS{1'b0}}});
                div_den = sum_reg;
            end
            OP_LOAD: begin
                div_num = NUM_W'({load_prod, {FRAC_BITS{1'b0}}});
                div_den = DEN_W'(cnt1000);
                div_cap = QW'(LOAD_CAP);
            end
            default: ;
        endcase
    end

    frm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QW    (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .cap     (div_cap),
        .done    (div_done),
        .quot    (div_quot)
    );

    // quality thresholds against the average rate, and the load warning level
    assign avg10  = (THR_W'(avg_reg) << 3) + (THR_W'(avg_reg) << 1);
    assign tgt_q  = THR_W'({target_fps_reg, {FRAC_BITS{1'b0}}});
    assign thr8   = tgt_q << 3;
    assign thr6   = (tgt_q << 2) + (tgt_q << 1);
    assign thr9   = (tgt_q << 3) + tgt_q;
    assign warn_q = QW'({load_warn_reg, {FRAC_BITS{1'b0}}});
    assign reduce = (count_reg >= CNT_W'(MIN_SAMPLES)) &&
                    ((avg10 < thr8) || (load_reg > warn_q));

    always_comb begin
        priority if (avg10 < thr6) begin
            level = QL_LOW;
        end else if (avg10 < thr9) begin
            level = QL_MEDIUM;
        end else begin
            level = QL_HIGH;
        end
    end

    // result register and its valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_OUTPUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUTPUT) && out_free) begin
            m_cur_reg    <= RATE_OUT_W'(cur_reg);
            m_avg_reg    <= RATE_OUT_W'(avg_reg);
            m_load_reg   <= LOAD_OUT_W'(load_reg);
            m_reduce_reg <= reduce;
            m_level_reg  <= level;
            m_ema_reg    <= RATE_OUT_W'(ema_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_fps_q8 = m_cur_reg;
    assign m_average_fps_q8 = m_avg_reg;
    assign m_load_pct_q8    = m_load_reg;
    assign m_reduce_quality = m_reduce_reg;
    assign m_quality_level  = m_level_reg;
    assign m_ema_fps_q8     = m_ema_reg;

    // checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_UPDATE)
        else $error("input transfer not followed by ring update");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIVIDE)
        else $error("divider finished outside the divide state");

    a_rates_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUTPUT |-> load_reg <= QW'(LOAD_CAP) && avg_reg <= QW'(RATE_MAX))
        else $error("load or average rate above its cap");

endmodule

/* rtl/frm_div.sv */
// bit-serial restoring divider with saturating quotient
module frm_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 20,
    parameter int QW    = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [QW-1:0]    cap,
    output logic             done,
    output logic [QW-1:0]    quot
);

    localparam int CMP_W  = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
    localparam int STEP_W = $clog2(QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QW-1:0]     shf_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QW-1:0]     cap_reg;
    logic [QW-1:0]     quot_reg;

    logic [CMP_W-1:0]  num_ext;
    logic [CMP_W-1:0]  den_sh;
    logic [CMP_W-1:0]  num_hi;
    logic              den_zero;
    logic              overflow;
    logic [DEN_W:0]    partial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [QW-1:0]     q_final;

    // start checks: zero divisor and quotient beyond QW bits
    assign num_ext  = CMP_W'(num);
    assign den_sh   = CMP_W'(den) << QW;
    assign num_hi   = num_ext >> QW;
    assign den_zero = (den == '0);
    assign overflow = (num_ext >= den_sh);

    // one quotient bit per cycle
    assign partial = {rem_reg, shf_reg[QW-1]};
    assign ge      = (partial >= {1'b0, den_reg});
    assign diff    = partial - {1'b0, den_reg};
    assign q_final = (shf_reg > cap_reg) ? cap_reg : shf_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den_zero || overflow) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(QW);
                end
            end else if (busy_reg) begin
                if (step_reg != '0) begin
                    step_reg <= step_reg - STEP_W'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi[DEN_W-1:0];
            shf_reg <= num[QW-1:0];
            den_reg <= den;
            cap_reg <= cap;
            if (den_zero) begin
                quot_reg <= '0;
            end else if (overflow) begin
                quot_reg <= cap;
            end
        end else if (busy_reg) begin
            if (step_reg != '0) begin
                rem_reg <= ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
                shf_reg <= {shf_reg[QW-2:0], ge};
            end else begin
                quot_reg <= q_final;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* dv/frame_rate_monitor_top_tb.sv */
// testbench for the frame rate monitor: directed and random frame times checked against a predictor
`timescale 1ns / 100ps

module frame_rate_monitor_top_tb;
    import frm_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;
    localparam int IDLE_PCT      = 24;
    localparam int PHASE_ITEMS   = 130;
    localparam int RANDOM_PHASES = 8;

    // index past the register list, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint unsigned RATE_CAP = longint'(K1000) << FRAC_BITS_DEF;
    localparam longint unsigned LOAD_CAP = longint'(LOAD_FULL) << FRAC_BITS_DEF;

    typedef struct {
        logic [RATE_OUT_W-1:0] cur_rate;
        logic [RATE_OUT_W-1:0] avg_rate;
        logic [LOAD_OUT_W-1:0] load_pct;
        logic                  reduce_quality;
        logic [LEVEL_W-1:0]    quality_level;
        logic [RATE_OUT_W-1:0] ema_fps;
    } frame_stats_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FT_W-1:0]       s_frame_time_ms = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [RATE_OUT_W-1:0] m_current_fps_q8;
    logic [RATE_OUT_W-1:0] m_average_fps_q8;
    logic [LOAD_OUT_W-1:0] m_load_pct_q8;
    logic                  m_reduce_quality;
    logic [LEVEL_W-1:0]    m_quality_level;
    logic [RATE_OUT_W-1:0] m_ema_fps_q8;

    // predictor copy of registers and state
    logic [TGT_W-1:0]  tgt_fps;
    logic [WIN_W-1:0]  win_len_ms;
    logic [LWP_W-1:0]  warn_pct;
    logic [FT_W-1:0]   ring_ms [RING_DEPTH_DEF];
    int unsigned       ring_wp;
    int unsigned       ring_count;
    longint unsigned   ring_total;
    longint unsigned   win_elapsed;
    longint unsigned   win_frames;
    longint unsigned   ema_q8;

    frame_stats_t stats_q[$];
    int           fail_count = 0;
    int           stall_cycles = 0;
    bit           no_idle = 1'b0;

    frame_rate_monitor_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_time_ms  (s_frame_time_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_fps_q8 (m_current_fps_q8),
        .m_average_fps_q8 (m_average_fps_q8),
        .m_load_pct_q8    (m_load_pct_q8),
        .m_reduce_quality (m_reduce_quality),
        .m_quality_level  (m_quality_level),
        .m_ema_fps_q8     (m_ema_fps_q8)
    );

    // clock, 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // predictor state after reset
    task automatic clear_predictor();
        tgt_fps     = TARGET_FPS_RST;
        win_len_ms  = WINDOW_MS_RST;
        warn_pct    = LOAD_WARN_RST;
        foreach (ring_ms[i]) ring_ms[i] = '0;
        ring_wp     = 0;
        ring_count  = 0;
        ring_total  = 0;
        win_elapsed = 0;
        win_frames  = 0;
        ema_q8      = 0;
    endtask

    // store one frame, update window and ema, return the rates it yields
    function automatic frame_stats_t predict_frame(input logic [FT_W-1:0] t);
        frame_stats_t    r;
        longint unsigned tgt;
        longint unsigned cur;
        longint unsigned avg;
        longint unsigned load;
        longint unsigned win_rate;
        longint unsigned raw;
        logic [LEVEL_W-1:0] level;

        tgt = longint'(tgt_fps) << FRAC_BITS_DEF;

        // ring and running sum
        ring_total = ring_total - ring_ms[ring_wp] + t;
        ring_ms[ring_wp] = t;
        ring_wp = (ring_wp + 1) % RING_DEPTH_DEF;
        if (ring_count < RING_DEPTH_DEF) ring_count++;

        // time window, ema update on close
        win_elapsed += t;
        if (win_frames != 64'hFFFF_FFFF) win_frames++;
        if (win_elapsed >= win_len_ms) begin
            win_rate = 0;
            if (win_elapsed > 0) begin
                raw = ((win_frames * K1000) << FRAC_BITS_DEF) / win_elapsed;
                win_rate = (raw > RATE_CAP) ? RATE_CAP : raw;
            end
            if (ema_q8 == 0)
                ema_q8 = win_rate;
            else
                ema_q8 = (EMA_NEW_WT * win_rate + EMA_OLD_WT * ema_q8) / EMA_DIV;
            win_elapsed = 0;
            win_frames  = 0;
        end

        // instantaneous and ring rates
        cur = (t > 0) ? (longint'(K1000) << FRAC_BITS_DEF) / t : 0;
        avg = 0;
        if (ring_total > 0) begin
            raw = ((longint'(ring_count) * K1000) << FRAC_BITS_DEF) / ring_total;
            avg = (raw > RATE_CAP) ? RATE_CAP : raw;
        end
        load = ((ring_total * tgt_fps * LOAD_FULL) << FRAC_BITS_DEF)
               / (longint'(K1000) * ring_count);
        if (load > LOAD_CAP) load = LOAD_CAP;

        // quality advice
        if (avg * 10 < tgt * 6)
            level = QL_LOW;
        else if (avg * 10 < tgt * 9)
            level = QL_MEDIUM;
        else
            level = QL_HIGH;

        r.cur_rate       = RATE_OUT_W'(cur);
        r.avg_rate       = RATE_OUT_W'(avg);
        r.load_pct       = LOAD_OUT_W'(load);
        r.reduce_quality = (ring_count >= MIN_SAMPLES) &&
                           (avg * 10 < tgt * 8 ||
                            load > (longint'(warn_pct) << FRAC_BITS_DEF));
        r.quality_level  = level;
        r.ema_fps        = RATE_OUT_W'(ema_q8);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        frame_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stats_q.size() == 0) begin
                $error("result transfer with no expectation pending");
                fail_count++;
            end else begin
                want = stats_q.pop_front();
                check_field("current_fps_q8", want.cur_rate, m_current_fps_q8);
                check_field("average_fps_q8", want.avg_rate, m_average_fps_q8);
                check_field("load_pct_q8", want.load_pct, m_load_pct_q8);
                check_field("reduce_quality", want.reduce_quality, m_reduce_quality);
                check_field("quality_level", want.quality_level, m_quality_level);
                check_field("ema_fps_q8", want.ema_fps, m_ema_fps_q8);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one frame time transfer, with random idle cycles ahead of it unless no_idle is set
    task automatic send_frame(input logic [FT_W-1:0] t);
        @(negedge aclk);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid         = 1'b1;
        s_frame_time_ms = t;
        do @(posedge aclk); while (!s_ready);
        stats_q.push_back(predict_frame(t));
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (stats_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_TARGET_FPS: tgt_fps    = data[TGT_W-1:0];
            REG_WINDOW_MS:  win_len_ms = data[WIN_W-1:0];
            REG_LOAD_WARN:  warn_pct   = data[LWP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] target,
                              input logic [CFG_DATA_W-1:0] window,
                              input logic [CFG_DATA_W-1:0] warn);
        wait_idle();
        write_reg(REG_TARGET_FPS, target);
        write_reg(REG_WINDOW_MS, window);
        write_reg(REG_LOAD_WARN, warn);
    endtask

    // mix of typical, near-target, zero, maximal and full-range frame times
    function automatic logic [FT_W-1:0] random_frame();
        int unsigned period;
        period = (tgt_fps != 0) ? K1000 / tgt_fps : 50;
        case ($urandom_range(19))
            0:          return '0;
            1:          return '1;
            2, 3:       return FT_W'($urandom_range(65535));
            4:          return FT_W'(1) << $urandom_range(FT_W - 1);
            5, 6, 7, 8: return FT_W'(period + $urandom_range(period));
            9:          return FT_W'($urandom_range(1, 3));
            default:    return FT_W'($urandom_range(4, 120));
        endcase
    endfunction

    // fresh ring: zero time, saturated ring and window rates, zero window length
    task automatic test_rate_saturation();
        set_config(TARGET_FPS_RST, 16'd1, LOAD_WARN_RST);
        send_frame(16'd0);
        send_frame(16'd1);
        send_frame(16'hFFFF);
        set_config(TARGET_FPS_RST, 16'd0, LOAD_WARN_RST);
        send_frame(16'd0);
        send_frame(16'd7);
    endtask

    // reset-value registers, a normal run that fills four samples and closes a window
    task automatic test_default_config();
        set_config(TARGET_FPS_RST, WINDOW_MS_RST, LOAD_WARN_RST);
        send_frame(16'd16);
        send_frame(16'd17);
        send_frame(16'd16);
        send_frame(16'd16);
        send_frame(16'd40);
        send_frame(16'd1000);
        send_frame(16'd25);
    endtask

    // register extremes, masking of wide data, ignored index, zero target
    task automatic test_register_extremes();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_frame(16'd3);
        send_frame(16'd4);
        set_config(16'd0, 16'd100, 16'd0);
        write_reg(REG_UNUSED, 16'h0000);
        send_frame(16'd2);
        send_frame(16'd100);
        set_config(16'd1, 16'd50, 16'd0);
        send_frame(16'd1000);
        send_frame(16'd2);
        set_config(16'd240, 16'd60000, 16'd100);
        send_frame(16'd4);
    endtask

    // sender holds off after every fifth frame until the block has drained
    task automatic test_drain_pauses(input int n);
        set_config(16'd30, 16'd200, 16'd90);
        for (int i = 0; i < n; i++) begin
            send_frame(random_frame());
            if (i % 5 == 4) wait_idle();
        end
    endtask

    // random frames under one configuration per phase
    task automatic test_random_traffic(input int phase);
        logic [CFG_DATA_W-1:0] target;
        logic [CFG_DATA_W-1:0] window;
        logic [CFG_DATA_W-1:0] warn;
        case (phase)
            0: begin target = 16'd1;   window = 16'd1;     warn = 16'd0;   end
            1: begin target = 16'd240; window = 16'd60000; warn = 16'd100; end
            2: begin target = 16'hABFF; window = 16'hFFFF; warn = 16'd127; end
            3: begin target = 16'd0;   window = 16'd0;     warn = 16'($urandom_range(100)); end
            default: begin
                target = {8'($urandom_range(255)), 8'($urandom_range(1, 240))};
                window = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                  : 16'($urandom_range(1, 2000));
                warn   = {9'($urandom_range(511)), 7'($urandom_range(100))};
            end
        endcase
        set_config(target, window, warn);
        // one phase runs with no idling on either side
        no_idle = (phase == 4);
        for (int i = 0; i < PHASE_ITEMS; i++) send_frame(random_frame());
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        clear_predictor();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_rate_saturation();
        test_default_config();
        test_register_extremes();
        test_drain_pauses(40);
        for (int p = 0; p < RANDOM_PHASES; p++) test_random_traffic(p);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/frm_pkg.sv
rtl/frm_div.sv
rtl/frame_rate_monitor_top.sv
dv/frame_rate_monitor_top_tb.sv
